/* sv/sads_pkg.sv */
// ----------------------------------------------------------------------------
// sads_pkg: shared types and constants for the double stack
// Store geometry, request and status codes, controller states, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sads_pkg;

  localparam int STORE_DEPTH = 128;
  localparam int WORD_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W       = FILL_W + 1;

  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(STORE_DEPTH);

  typedef enum logic [1:0] {
    MODE_PUSH_LEFT  = 2'd0,
    MODE_PUSH_RIGHT = 2'd1,
    MODE_POP_LEFT   = 2'd2,
    MODE_POP_RIGHT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_L,
    OP_PUSH_R,
    OP_POP_L,
    OP_POP_R
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;      // latch the incoming request word
    op_t     op;           // memory access and pointer update to perform
    logic    load_result;  // register the outcome code
    status_t result;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t req_mode;
    logic  full;
    logic  left_empty;
    logic  right_empty;
  } dp_sts_t;

endpackage

/* sv/sads_if.sv */
// ----------------------------------------------------------------------------
// sads_in_if / sads_out_if: request and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sads_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  mode;
  logic signed [31:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface sads_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pop_value;
  logic        [1:0]  status;
  logic        [7:0]  left_count;
  logic        [7:0]  right_count;

  modport source (output valid, output pop_value, output status,
                  output left_count, output right_count, input ready);
  modport sink   (input valid, input pop_value, input status,
                  input left_count, input right_count, output ready);
endinterface

/* sv/shared_array_double_stack.sv */
// ----------------------------------------------------------------------------
// shared_array_double_stack: two stacks in one word store
// Left stack grows up from word 0, right stack grows down from the top word.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+------------------------------------
//  in_ch   | in  | valid/ready        | mode, push_value
//  out_ch  | out | valid/ready        | pop_value, status, left/right_count
//
//  Sequence: each request passes accept, execute and present in turn;
//    the single store port and its registered read set the execute step.
//  Reset: synchronous, active low; clears both fill counts and the FSM.
//    The store itself is not cleared; a pop never reads an unwritten word.
//  Stalls: while out_ch.ready is low the result is held and in_ch.ready
//    stays low; no new request is taken until the result word leaves.
//
module shared_array_double_stack (
  input logic       clk,
  input logic       rst_n,
  sads_in_if.sink   in_ch,
  sads_out_if.source out_ch
);
  import sads_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: handshakes and push/pop/refuse decision.
  sads_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: word store, fill counters, held result word.
  sads_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_ch.mode),
    .in_push_value   (in_ch.push_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_pop_value   (out_ch.pop_value),
    .out_status      (out_ch.status),
    .out_left_count  (out_ch.left_count),
    .out_right_count (out_ch.right_count)
  );

endmodule

/* sv/sads_ctrl.sv */
// ----------------------------------------------------------------------------
// sads_ctrl: request sequencer
// Accepts a request, decides push/pop or refusal from the fill flags,
// then presents the result until it is taken.
// ----------------------------------------------------------------------------
module sads_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sads_pkg::dp_sts_t sts,
  output sads_pkg::dp_cmd_t cmd
);
  import sads_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd.capture     = 1'b0;
    cmd.op          = OP_NONE;
    cmd.load_result = 1'b0;
    cmd.result      = ST_DONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.load_result = 1'b1;
        case (sts.req_mode)
          MODE_PUSH_LEFT: begin
            if (sts.full) cmd.result = ST_FULL;
            else          cmd.op     = OP_PUSH_L;
          end
          MODE_PUSH_RIGHT: begin
            if (sts.full) cmd.result = ST_FULL;
            else          cmd.op     = OP_PUSH_R;
          end
          MODE_POP_LEFT: begin
            if (sts.left_empty) cmd.result = ST_EMPTY;
            else                cmd.op     = OP_POP_L;
          end
          default: begin
            if (sts.right_empty) cmd.result = ST_EMPTY;
            else                 cmd.op     = OP_POP_R;
          end
        endcase
        state_nxt = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("sads_ctrl: request and result sides open together");

  a_exec_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> out_valid)
    else $error("sads_ctrl: result not presented after execute");

endmodule

/* sv/sads_dp.sv */
// ----------------------------------------------------------------------------
// sads_dp: store, fill counters and result registers
// One 32-bit word store addressed from both ends, registered read port.
// ----------------------------------------------------------------------------
module sads_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      in_mode,
  input  logic signed [sads_pkg::WORD_W-1:0] in_push_value,
  input  sads_pkg::dp_cmd_t               cmd,
  output sads_pkg::dp_sts_t               sts,
  output logic signed [sads_pkg::WORD_W-1:0] out_pop_value,
  output logic [1:0]                      out_status,
  output logic [sads_pkg::COUNT_W-1:0]    out_left_count,
  output logic [sads_pkg::COUNT_W-1:0]    out_right_count
);
  import sads_pkg::*;

  logic [WORD_W-1:0] word_mem [STORE_DEPTH];

  mode_t             mode_r;
  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] rd_data_r;
  logic [FILL_W-1:0] left_fill_r, left_fill_nxt;
  logic [FILL_W-1:0] right_fill_r, right_fill_nxt;
  status_t           status_r;
  logic              pop_ok_r;

  logic [SUM_W-1:0]  fill_sum;
  logic [SUM_W-1:0]  addr_wide;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [FILL_W+COUNT_W-1:0] left_ext, right_ext;

  assign fill_sum = {1'b0, left_fill_r} + {1'b0, right_fill_r};

  assign sts.req_mode    = mode_r;
  assign sts.full        = (fill_sum >= DEPTH_SUM);
  assign sts.left_empty  = (left_fill_r == '0);
  assign sts.right_empty = (right_fill_r == '0);

  // address of the word touched, counted from the proper end
  always_comb begin
    addr_wide      = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    left_fill_nxt  = left_fill_r;
    right_fill_nxt = right_fill_r;
    case (cmd.op)
      OP_PUSH_L: begin
        addr_wide     = {1'b0, left_fill_r};
        mem_we        = 1'b1;
        left_fill_nxt = left_fill_r + FILL_W'(1);
      end
      OP_PUSH_R: begin
        addr_wide      = DEPTH_SUM - SUM_W'(1) - {1'b0, right_fill_r};
        mem_we         = 1'b1;
        right_fill_nxt = right_fill_r + FILL_W'(1);
      end
      OP_POP_L: begin
        addr_wide     = {1'b0, left_fill_r} - SUM_W'(1);
        mem_re        = 1'b1;
        left_fill_nxt = left_fill_r - FILL_W'(1);
      end
      OP_POP_R: begin
        addr_wide      = DEPTH_SUM - {1'b0, right_fill_r};
        mem_re         = 1'b1;
        right_fill_nxt = right_fill_r - FILL_W'(1);
      end
      default: begin
        addr_wide = '0;
      end
    endcase
  end

  assign mem_addr = addr_wide[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_mem[mem_addr] <= word_r;
    end
    if (mem_re) begin
      rd_data_r <= word_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_t'(in_mode);
      word_r <= in_push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_fill_r  <= '0;
      right_fill_r <= '0;
      status_r     <= ST_DONE;
      pop_ok_r     <= 1'b0;
    end else begin
      left_fill_r  <= left_fill_nxt;
      right_fill_r <= right_fill_nxt;
      if (cmd.load_result) begin
        status_r <= cmd.result;
        pop_ok_r <= mem_re;
      end
    end
  end

  assign left_ext  = {{COUNT_W{1'b0}}, left_fill_r};
  assign right_ext = {{COUNT_W{1'b0}}, right_fill_r};

  assign out_pop_value   = pop_ok_r ? rd_data_r : '0;
  assign out_status      = status_r;
  assign out_left_count  = left_ext[COUNT_W-1:0];
  assign out_right_count = right_ext[COUNT_W-1:0];

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_sum <= DEPTH_SUM)
    else $error("sads_dp: stacks overlap");

  a_push_left: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUSH_L) |=> (left_fill_r == $past(left_fill_r) + FILL_W'(1)))
    else $error("sads_dp: left push did not advance the pointer");

  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_result && cmd.result != ST_DONE) |=>
      ($stable(left_fill_r) && $stable(right_fill_r)))
    else $error("sads_dp: refused request moved a pointer");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_result && cmd.result != ST_DONE) |=> (out_pop_value == '0))
    else $error("sads_dp: refused request returned data");

endmodule
